>>> design/mscg_pkg.sv
// Package for the multi-stop colour gradient: request and status codes,
// default sizes and the request descriptor passed from the front to the engine.
// No dependencies.
package mscg_pkg;

  localparam int DefMaxStops    = 16;
  localparam int DefPositionBits = 16;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_BADIDX = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  stop_index;
    logic [31:0] color;
  } req_desc_t;

endpackage

>>> design/multi_stop_color_gradient.sv
// Top level of the multi-stop colour gradient: front queue and engine.
// Depends on mscg_pkg, mscg_front and mscg_engine.
//
//   channel | handshake          | fields
//   input   | in_valid/in_stall  | req_type stop_index position in_alpha in_red in_green in_blue
//   output  | out_valid/out_stall| out_alpha out_red out_green out_blue status stop_count
//           |                    | is_translucent
//
// Clear and bad-index set go straight to the result, set first writes the table; add and
// lookup scan one stop a cycle, and a blended lookup then loads the upper stop, divides and blends.
// The divider yields one fraction bit a cycle; the blender one channel a cycle.
// rst is synchronous and empties the table and queue; table contents are not cleared.
// A stalled output holds the next result; the two-entry queue takes requests until full.
module multi_stop_color_gradient import mscg_pkg::*; #(
  parameter int MAX_STOPS     = DefMaxStops,
  parameter int POSITION_BITS = DefPositionBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  stop_index,
  input  logic [15:0] position,
  input  logic [7:0]  in_alpha,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_alpha,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [2:0]  status,
  output logic [4:0]  stop_count,
  output logic        is_translucent
);

  logic                     q_valid, q_pop;
  req_desc_t                q_desc;
  logic [POSITION_BITS-1:0] q_pos;

  mscg_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .stop_index, .position,
    .in_alpha, .in_red, .in_green, .in_blue, .q_valid, .q_desc, .q_pos, .q_pop
  );

  mscg_engine #(.MAX_STOPS(MAX_STOPS), .POSITION_BITS(POSITION_BITS)) u_engine (
    .clk, .rst, .q_valid, .q_desc, .q_pos, .q_pop, .out_valid, .out_stall,
    .out_alpha, .out_red, .out_green, .out_blue, .status, .stop_count, .is_translucent
  );

endmodule

>>> design/mscg_front.sv
// Front of the gradient block: accepts requests, clamps the position, packs
// the colour and holds them in a two-entry queue. Depends on mscg_pkg.
module mscg_front import mscg_pkg::*; #(
  parameter int POSITION_BITS = DefPositionBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               req_type,
  input  logic [3:0]               stop_index,
  input  logic [15:0]              position,
  input  logic [7:0]               in_alpha,
  input  logic [7:0]               in_red,
  input  logic [7:0]               in_green,
  input  logic [7:0]               in_blue,
  output logic                     q_valid,
  output req_desc_t                q_desc,
  output logic [POSITION_BITS-1:0] q_pos,
  input  logic                     q_pop
);

  localparam logic [23:0] PosMax = 24'((64'd1 << POSITION_BITS) - 64'd1);

  req_desc_t                desc_q [2];
  logic [POSITION_BITS-1:0] pos_q  [2];
  logic                     wp, rp;
  logic [1:0]               fill;
  logic [23:0]              pos_ext;
  logic [POSITION_BITS-1:0] pos_c;
  logic                     push, pop;

  assign pos_ext  = 24'(position);
  assign pos_c    = (pos_ext > PosMax) ? PosMax[POSITION_BITS-1:0]
                                       : pos_ext[POSITION_BITS-1:0];
  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (fill != 2'd0);
  assign q_desc   = desc_q[rp];
  assign q_pos    = pos_q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      desc_q[wp] <= '{req_type: req_type, stop_index: stop_index,
                      color: {in_alpha, in_red, in_green, in_blue}};
      pos_q[wp]  <= pos_c;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> design/mscg_engine.sv
// Back of the gradient block: stop table, scan sequencer, divider, blender
// and the result register. Depends on mscg_pkg.
module mscg_engine import mscg_pkg::*; #(
  parameter int MAX_STOPS     = DefMaxStops,
  parameter int POSITION_BITS = DefPositionBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  req_desc_t                q_desc,
  input  logic [POSITION_BITS-1:0] q_pos,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_alpha,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output logic [2:0]               status,
  output logic [4:0]               stop_count,
  output logic                     is_translucent
);

  localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam int PB = POSITION_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_EXEC, S_SETW, S_LOADHI, S_DIVPREP, S_DIV, S_BLEND, S_FINISH
  } state_t;

  state_t         state;
  logic [PB-1:0]  pos_mem [MAX_STOPS];
  logic [31:0]    col_mem [MAX_STOPS];
  logic [CW-1:0]  n, trans_cnt, i, hit;
  logic           equal;
  req_desc_t      cur;
  logic [PB-1:0]  p, lo_pos, hi_pos, d, r;
  logic [31:0]    lo_col, hi_col, res_col;
  logic [15:0]    q, frac;
  logic [3:0]     div_cnt;
  logic [1:0]     ch;
  logic [2:0]     st;
  logic [CW-1:0]  hm1, nm1;
  logic [PB:0]    r2;
  logic signed [8:0]  diff;
  logic signed [26:0] prod;
  logic [7:0]     byte_v;
  logic           new_tr, old_tr;

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign hm1    = hit - 1'b1;
  assign nm1    = n - 1'b1;
  assign r2     = {r, 1'b0};
  assign diff   = $signed({1'b0, hi_col[8*ch +: 8]}) - $signed({1'b0, lo_col[8*ch +: 8]});
  assign prod   = diff * $signed({1'b0, frac, 1'b0}) ;
  assign byte_v = lo_col[8*ch +: 8] + 8'(prod >>> 17);
  assign new_tr = (cur.color[31:24] != 8'hFF);
  assign old_tr = (col_mem[cur.stop_index[IW-1:0]][31:24] != 8'hFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      trans_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_desc;
            p       <= q_pos;
            i       <= '0;
            equal   <= 1'b0;
            st      <= ST_OK;
            res_col <= '0;
            unique case (q_desc.req_type)
              REQ_ADD, REQ_LOOKUP: state <= S_SCAN;
              REQ_SET: begin
                if (32'(q_desc.stop_index) >= 32'(n)) begin
                  st    <= ST_BADIDX;
                  state <= S_FINISH;
                end else begin
                  state <= S_SETW;
                end
              end
              default: begin
                n         <= '0;
                trans_cnt <= '0;
                state     <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (i == n) begin
            hit   <= n;
            state <= S_EXEC;
          end else if (pos_mem[i[IW-1:0]] == p) begin
            hit   <= i;
            equal <= 1'b1;
            state <= S_EXEC;
          end else if (pos_mem[i[IW-1:0]] > p) begin
            hit   <= i;
            state <= S_EXEC;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_FINISH;
          if (cur.req_type == REQ_ADD) begin
            if (equal) begin
              st <= ST_DUP;
            end else if (32'(n) >= MAX_STOPS) begin
              st <= ST_FULL;
            end else begin
              for (int k = 1; k < MAX_STOPS; k++) begin
                if (k > int'(hit)) begin
                  pos_mem[k] <= pos_mem[k-1];
                  col_mem[k] <= col_mem[k-1];
                end
              end
              pos_mem[hit[IW-1:0]] <= p;
              col_mem[hit[IW-1:0]] <= cur.color;
              n         <= n + 1'b1;
              trans_cnt <= trans_cnt + CW'(new_tr);
            end
          end else begin
            if (n == '0) begin
              st <= ST_EMPTY;
            end else if (equal || hit == '0) begin
              res_col <= col_mem[hit[IW-1:0]];
            end else if (hit >= n) begin
              res_col <= col_mem[nm1[IW-1:0]];
            end else begin
              lo_pos <= pos_mem[hm1[IW-1:0]];
              lo_col <= col_mem[hm1[IW-1:0]];
              state  <= S_LOADHI;
            end
          end
        end
        S_SETW: begin
          pos_mem[cur.stop_index[IW-1:0]] <= p;
          col_mem[cur.stop_index[IW-1:0]] <= cur.color;
          trans_cnt <= trans_cnt - CW'(old_tr) + CW'(new_tr);
          state     <= S_FINISH;
        end
        S_LOADHI: begin
          hi_pos <= pos_mem[hit[IW-1:0]];
          hi_col <= col_mem[hit[IW-1:0]];
          state  <= S_DIVPREP;
        end
        S_DIVPREP: begin
          ch <= 2'd0;
          if (hi_pos > lo_pos && p >= lo_pos) begin
            r       <= p - lo_pos;
            d       <= hi_pos - lo_pos;
            q       <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            frac  <= '0;
            state <= S_BLEND;
          end
        end
        S_DIV: begin
          if (r2 >= {1'b0, d}) begin
            r <= PB'(r2 - {1'b0, d});
            q <= {q[14:0], 1'b1};
          end else begin
            r <= r2[PB-1:0];
            q <= {q[14:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'd15) begin
            frac  <= {q[14:0], (r2 >= {1'b0, d})};
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          res_col[8*ch +: 8] <= byte_v;
          ch <= ch + 1'b1;
          if (ch == 2'd3) state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            out_alpha      <= res_col[31:24];
            out_red        <= res_col[23:16];
            out_green      <= res_col[15:8];
            out_blue       <= res_col[7:0];
            status         <= st;
            stop_count     <= 5'(n);
            is_translucent <= (trans_cnt != '0);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
